FILE: hdl/mfsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mfsc_pkg;

  // Source screen geometry.
  localparam int SRC_WIDTH   = 400;
  localparam int SRC_HEIGHT  = 300;
  localparam int FRAME_BYTES = (SRC_WIDTH * SRC_HEIGHT + 7) / 8;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);
  localparam int SX_W        = $clog2(SRC_WIDTH + 1);
  localparam int SY_W        = $clog2(SRC_HEIGHT + 1);
  localparam int IDX_W       = $clog2(SRC_WIDTH * SRC_HEIGHT) + 1;
  localparam int SRC_MAX     = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;

  // Field widths.
  localparam int DIM_W      = 10;
  localparam int FMT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int DIVIDEND_W = $clog2(((1 << DIM_W) - 1) * SRC_MAX + 1);

  // Bordered 480x320 panel layout.
  localparam int BORDER_W   = 480;
  localparam int BORDER_H   = 320;
  localparam int PAD_LEFT   = (BORDER_W - SRC_WIDTH) / 2;
  localparam int PAD_TOP    = (BORDER_H - SRC_HEIGHT) / 2;
  localparam int RING_INNER = 2;
  localparam int RING_OUTER = 4;
  localparam int CHK_SIZE   = 6;
  localparam int CHK_SHIFT  = 12;
  localparam int CHK_RECIP  = ((1 << CHK_SHIFT) + CHK_SIZE - 1) / CHK_SIZE;
  localparam int CHK_RECIP_W = $clog2(CHK_RECIP + 1);

  localparam logic [15:0] COL_RING_INNER = 16'h39E7;
  localparam logic [15:0] COL_RING_OUTER = 16'h18C3;
  localparam logic [15:0] COL_CHK_EVEN   = 16'h2104;
  localparam logic [15:0] COL_CHK_ODD    = 16'h4A69;
  localparam logic [15:0] COL_WHITE      = 16'hFFFF;
  localparam logic [15:0] COL_GREY_ON    = 16'h00FF;

  // Register reset values.
  localparam logic [31:0]      RST_BASE     = 32'h0081_0000;
  localparam logic [DIM_W-1:0] RST_DEST_W   = 10'd480;
  localparam logic [DIM_W-1:0] RST_DEST_H   = 10'd320;
  localparam logic [FMT_W-1:0] RST_FMT      = 2'd1;
  localparam logic [31:0]      RST_INTERVAL = 32'd33;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_RENDER,
    OP_REFRESH
  } mfsc_op_t;

  typedef enum logic [1:0] {
    FMT_MONO01,
    FMT_MONO10,
    FMT_RGB565,
    FMT_GREY
  } mfsc_fmt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE,
    REG_DEST_W,
    REG_DEST_H,
    REG_FMT,
    REG_EPAPER,
    REG_INTERVAL
  } mfsc_reg_t;

  typedef enum logic [2:0] {
    MODE_OUTSIDE,
    MODE_RING,
    MODE_BORDER_SRC,
    MODE_DIRECT,
    MODE_SCALED
  } mfsc_mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_DIVX,
    ST_DIVY,
    ST_INDEX,
    ST_READ,
    ST_DONE
  } mfsc_state_t;

  typedef struct packed {
    logic clr_we;
    logic accept;
    logic decode;
    logic div_start;
    logic div_sel_y;
    logic sx_load_div;
    logic sy_load_div;
    logic src_load_direct;
    logic idx_load;
    logic mem_rd;
    logic commit;
  } mfsc_cmd_t;

  typedef struct packed {
    logic       clr_last;
    mfsc_op_t   op;
    mfsc_mode_t mode;
    logic       in_frame;
    logic       div_done;
    logic       out_free;
  } mfsc_status_t;

endpackage
`default_nettype wire

FILE: hdl/mfsc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module mfsc_div (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic [mfsc_pkg::DIVIDEND_W-1:0]     dividend,
  input  wire logic [mfsc_pkg::DIM_W-1:0]          divisor,
  output logic      [mfsc_pkg::DIVIDEND_W-1:0]     quotient,
  output logic                                     done
);

  localparam int CNT_W = $clog2(mfsc_pkg::DIVIDEND_W + 1);

  logic [mfsc_pkg::DIVIDEND_W-1:0] quo_r;
  logic [mfsc_pkg::DIM_W-1:0]      rem_r;
  logic [mfsc_pkg::DIM_W-1:0]      den_r;
  logic [CNT_W-1:0]                cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [mfsc_pkg::DIM_W:0]        rem_t;
  logic [mfsc_pkg::DIM_W:0]        diff;
  logic                            ge;

  always_comb begin
    rem_t = {rem_r, quo_r[mfsc_pkg::DIVIDEND_W-1]};
    diff  = rem_t - {1'b0, den_r};
    ge    = rem_t >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(mfsc_pkg::DIVIDEND_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[mfsc_pkg::DIVIDEND_W-2:0], ge};
      rem_r <= ge ? diff[mfsc_pkg::DIM_W-1:0] : rem_t[mfsc_pkg::DIM_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule
`default_nettype wire

FILE: hdl/mfsc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// Registers, frame memory, render arithmetic and the result register.
module mfsc_datapath (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire mfsc_pkg::mfsc_cmd_t                cmd,
  output mfsc_pkg::mfsc_status_t                  status,
  input  wire logic                               cfg_we,
  input  wire logic [mfsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [31:0]                        cfg_wdata,
  input  wire logic [1:0]                         in_cmd,
  input  wire logic [31:0]                        in_address,
  input  wire logic [7:0]                         in_write_data,
  input  wire logic [mfsc_pkg::DIM_W-1:0]         in_pixel_x,
  input  wire logic [mfsc_pkg::DIM_W-1:0]         in_pixel_y,
  input  wire logic [31:0]                        in_now_ms,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [7:0]                         out_read_data,
  output logic      [15:0]                        out_pixel_value,
  output logic                                    out_refresh_done,
  output logic                                    out_dirty_out
);

  localparam int AW = mfsc_pkg::ADDR_W;
  localparam int IW = mfsc_pkg::IDX_W;
  localparam int DW = mfsc_pkg::DIVIDEND_W;
  localparam int NW = mfsc_pkg::DIM_W;
  localparam int MW = NW + mfsc_pkg::CHK_RECIP_W;

  // Configuration.
  logic [31:0]                base_r;
  logic [NW-1:0]              dest_w_r;
  logic [NW-1:0]              dest_h_r;
  logic [mfsc_pkg::FMT_W-1:0] fmt_r;
  logic                       epaper_r;
  logic [31:0]                interval_r;

  // Captured request.
  mfsc_pkg::mfsc_op_t op_r;
  logic [31:0]        addr_r;
  logic [7:0]         wdata_r;
  logic [NW-1:0]      px_r;
  logic [NW-1:0]      py_r;
  logic [31:0]        now_r;

  // Work registers.
  logic [AW-1:0]             off_r;
  logic                      in_frame_r;
  mfsc_pkg::mfsc_mode_t      mode_r;
  logic [mfsc_pkg::SX_W-1:0] sx_r;
  logic [mfsc_pkg::SY_W-1:0] sy_r;
  logic [IW-1:0]             idx_r;
  logic [7:0]                rdata_r;
  logic [AW-1:0]             clr_cnt_r;

  // Device state.
  logic        dirty_r;
  logic        dirty_nxt;
  logic [31:0] last_r;
  logic [31:0] last_nxt;

  // Result register.
  logic        out_valid_r;
  logic [7:0]  rd_r;
  logic [15:0] pv_r;
  logic        done_r;
  logic        dout_r;

  logic [7:0] frame_mem [mfsc_pkg::FRAME_BYTES];

  // Combinational.
  logic [31:0]          off;
  logic                 in_frame_c;
  mfsc_pkg::mfsc_mode_t mode_c;
  int                   xi, yi, d;
  logic                 b_left, b_right, b_top, b_bottom, b_out;
  logic [MW-1:0]        mx, my;
  logic [15:0]          ring_pv;
  logic [DW-1:0]        div_dividend;
  logic [NW-1:0]        div_divisor;
  logic [DW-1:0]        div_quo;
  logic                 div_done;
  logic [IW-1:0]        idx_c;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [7:0]           mem_wdata;
  logic                 src_bit;
  logic [15:0]          pv_c;
  logic                 changed;
  logic                 wr_hit;
  logic [31:0]          elapsed;
  logic                 refresh_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= mfsc_pkg::RST_BASE;
      dest_w_r   <= mfsc_pkg::RST_DEST_W;
      dest_h_r   <= mfsc_pkg::RST_DEST_H;
      fmt_r      <= mfsc_pkg::RST_FMT;
      epaper_r   <= 1'b0;
      interval_r <= mfsc_pkg::RST_INTERVAL;
    end else if (cfg_we) begin
      case (cfg_index)
        mfsc_pkg::REG_BASE:     base_r     <= cfg_wdata;
        mfsc_pkg::REG_DEST_W:   dest_w_r   <= cfg_wdata[NW-1:0];
        mfsc_pkg::REG_DEST_H:   dest_h_r   <= cfg_wdata[NW-1:0];
        mfsc_pkg::REG_FMT:      fmt_r      <= cfg_wdata[mfsc_pkg::FMT_W-1:0];
        mfsc_pkg::REG_EPAPER:   epaper_r   <= cfg_wdata[0];
        mfsc_pkg::REG_INTERVAL: interval_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= mfsc_pkg::mfsc_op_t'(in_cmd);
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      px_r    <= in_pixel_x;
      py_r    <= in_pixel_y;
      now_r   <= in_now_ms;
    end
  end

  // Address decode, bordered-panel geometry and render-mode selection.
  always_comb begin
    off        = addr_r - base_r;
    in_frame_c = off < 32'(mfsc_pkg::FRAME_BYTES);
    xi       = int'(px_r);
    yi       = int'(py_r);
    b_left   = xi < mfsc_pkg::PAD_LEFT;
    b_right  = xi >= mfsc_pkg::PAD_LEFT + mfsc_pkg::SRC_WIDTH;
    b_top    = yi < mfsc_pkg::PAD_TOP;
    b_bottom = yi >= mfsc_pkg::PAD_TOP + mfsc_pkg::SRC_HEIGHT;
    b_out    = b_left || b_right || b_top || b_bottom;
    if (b_left) begin
      d = mfsc_pkg::PAD_LEFT - xi;
    end else if (b_right) begin
      d = xi - (mfsc_pkg::PAD_LEFT + mfsc_pkg::SRC_WIDTH);
    end else if (b_top) begin
      d = mfsc_pkg::PAD_TOP - yi;
    end else begin
      d = yi - (mfsc_pkg::PAD_TOP + mfsc_pkg::SRC_HEIGHT);
    end
    // Division by the checker size through a reciprocal; exact for these coordinates.
    mx = MW'(px_r) * MW'(mfsc_pkg::CHK_RECIP);
    my = MW'(py_r) * MW'(mfsc_pkg::CHK_RECIP);
    if (d < mfsc_pkg::RING_INNER) begin
      ring_pv = mfsc_pkg::COL_RING_INNER;
    end else if (d < mfsc_pkg::RING_OUTER) begin
      ring_pv = mfsc_pkg::COL_RING_OUTER;
    end else if (mx[mfsc_pkg::CHK_SHIFT] ^ my[mfsc_pkg::CHK_SHIFT]) begin
      ring_pv = mfsc_pkg::COL_CHK_ODD;
    end else begin
      ring_pv = mfsc_pkg::COL_CHK_EVEN;
    end

    if (px_r >= dest_w_r || py_r >= dest_h_r) begin
      mode_c = mfsc_pkg::MODE_OUTSIDE;
    end else if (dest_w_r == NW'(mfsc_pkg::BORDER_W) && dest_h_r == NW'(mfsc_pkg::BORDER_H)) begin
      mode_c = b_out ? mfsc_pkg::MODE_RING : mfsc_pkg::MODE_BORDER_SRC;
    end else if (dest_w_r == NW'(mfsc_pkg::SRC_WIDTH)
                 && dest_h_r == NW'(mfsc_pkg::SRC_HEIGHT)) begin
      mode_c = mfsc_pkg::MODE_DIRECT;
    end else begin
      mode_c = mfsc_pkg::MODE_SCALED;
    end
  end

  always_comb begin
    if (cmd.div_sel_y) begin
      div_dividend = DW'(py_r) * DW'(mfsc_pkg::SRC_HEIGHT);
      div_divisor  = dest_h_r;
    end else begin
      div_dividend = DW'(px_r) * DW'(mfsc_pkg::SRC_WIDTH);
      div_divisor  = dest_w_r;
    end
  end

  mfsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign idx_c = IW'(sy_r) * IW'(mfsc_pkg::SRC_WIDTH) + IW'(sx_r);

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      off_r      <= off[AW-1:0];
      in_frame_r <= in_frame_c;
      mode_r     <= mode_c;
    end
    if (cmd.src_load_direct) begin
      if (mode_c == mfsc_pkg::MODE_DIRECT) begin
        sx_r <= mfsc_pkg::SX_W'(px_r);
        sy_r <= mfsc_pkg::SY_W'(py_r);
      end else begin
        sx_r <= mfsc_pkg::SX_W'(xi - mfsc_pkg::PAD_LEFT);
        sy_r <= mfsc_pkg::SY_W'(yi - mfsc_pkg::PAD_TOP);
      end
    end
    if (cmd.sx_load_div) begin
      sx_r <= (div_quo >= DW'(mfsc_pkg::SRC_WIDTH)) ?
              mfsc_pkg::SX_W'(mfsc_pkg::SRC_WIDTH - 1) : mfsc_pkg::SX_W'(div_quo);
    end
    if (cmd.sy_load_div) begin
      sy_r <= (div_quo >= DW'(mfsc_pkg::SRC_HEIGHT)) ?
              mfsc_pkg::SY_W'(mfsc_pkg::SRC_HEIGHT - 1) : mfsc_pkg::SY_W'(div_quo);
    end
    if (cmd.idx_load) begin
      idx_r <= idx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_we) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Frame memory: one write port shared by the clearing pass and bus writes.
  assign mem_raddr = (op_r == mfsc_pkg::OP_RENDER) ? idx_r[AW+2:3] : off_r;
  assign changed   = rdata_r != wdata_r;
  assign wr_hit    = (op_r == mfsc_pkg::OP_WRITE) && in_frame_r && changed;
  assign mem_we    = cmd.clr_we || (cmd.commit && wr_hit);
  assign mem_waddr = cmd.clr_we ? clr_cnt_r : off_r;
  assign mem_wdata = cmd.clr_we ? 8'h00 : wdata_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= frame_mem[mem_raddr];
    end
  end

  // Pixel formation.
  always_comb begin
    src_bit = (idx_r[IW-1:3] < (IW-3)'(mfsc_pkg::FRAME_BYTES))
              && rdata_r[3'd7 - idx_r[2:0]];
    case (mode_r)
      mfsc_pkg::MODE_RING:       pv_c = ring_pv;
      mfsc_pkg::MODE_BORDER_SRC: pv_c = src_bit ? mfsc_pkg::COL_WHITE : 16'h0000;
      mfsc_pkg::MODE_DIRECT: begin
        case (fmt_r)
          mfsc_pkg::FMT_MONO01: pv_c = {15'd0, src_bit};
          mfsc_pkg::FMT_MONO10: pv_c = {15'd0, !src_bit};
          mfsc_pkg::FMT_RGB565: pv_c = src_bit ? mfsc_pkg::COL_WHITE : 16'h0000;
          default:              pv_c = src_bit ? mfsc_pkg::COL_GREY_ON : 16'h0000;
        endcase
      end
      mfsc_pkg::MODE_SCALED: begin
        if (fmt_r == mfsc_pkg::FMT_RGB565) begin
          pv_c = src_bit ? mfsc_pkg::COL_WHITE : 16'h0000;
        end else begin
          pv_c = src_bit ? mfsc_pkg::COL_GREY_ON : 16'h0000;
        end
      end
      default: pv_c = 16'h0000;
    endcase
  end

  // Refresh and dirty tracking.
  always_comb begin
    elapsed    = now_r - last_r;
    refresh_ok = dirty_r && !(epaper_r && elapsed < interval_r);
    dirty_nxt  = dirty_r;
    last_nxt   = last_r;
    if (op_r == mfsc_pkg::OP_WRITE && wr_hit) begin
      dirty_nxt = 1'b1;
    end else if (op_r == mfsc_pkg::OP_REFRESH && refresh_ok) begin
      dirty_nxt = 1'b0;
      last_nxt  = now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r     <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        dirty_r     <= dirty_nxt;
        last_r      <= last_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rd_r   <= (op_r == mfsc_pkg::OP_READ && in_frame_r) ? rdata_r : 8'h00;
      pv_r   <= (op_r == mfsc_pkg::OP_RENDER) ? pv_c : 16'h0000;
      done_r <= (op_r == mfsc_pkg::OP_REFRESH) && refresh_ok;
      dout_r <= dirty_nxt;
    end
  end

  always_comb begin
    status.clr_last = clr_cnt_r == AW'(mfsc_pkg::FRAME_BYTES - 1);
    status.op       = op_r;
    status.mode     = mode_c;
    status.in_frame = in_frame_c;
    status.div_done = div_done;
    status.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_read_data    = rd_r;
  assign out_pixel_value  = pv_r;
  assign out_refresh_done = done_r;
  assign out_dirty_out    = dout_r;

endmodule
`default_nettype wire

FILE: hdl/mfsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Sequencer for one request at a time.
module mfsc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire mfsc_pkg::mfsc_status_t status,
  output mfsc_pkg::mfsc_cmd_t         cmd
);

  mfsc_pkg::mfsc_state_t state_r;
  mfsc_pkg::mfsc_state_t state_nxt;
  logic                  render;
  logic                  direct_src;

  assign render     = status.op == mfsc_pkg::OP_RENDER;
  assign direct_src = status.mode inside {mfsc_pkg::MODE_BORDER_SRC, mfsc_pkg::MODE_DIRECT};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfsc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfsc_pkg::ST_CLEAR: begin
        if (status.clr_last) state_nxt = mfsc_pkg::ST_IDLE;
      end
      mfsc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mfsc_pkg::ST_DECODE;
      end
      mfsc_pkg::ST_DECODE: begin
        case (status.op)
          mfsc_pkg::OP_WRITE, mfsc_pkg::OP_READ: begin
            state_nxt = status.in_frame ? mfsc_pkg::ST_READ : mfsc_pkg::ST_DONE;
          end
          mfsc_pkg::OP_RENDER: begin
            if (status.mode == mfsc_pkg::MODE_SCALED) begin
              state_nxt = mfsc_pkg::ST_DIVX;
            end else if (direct_src) begin
              state_nxt = mfsc_pkg::ST_INDEX;
            end else begin
              state_nxt = mfsc_pkg::ST_DONE;
            end
          end
          default: state_nxt = mfsc_pkg::ST_DONE;
        endcase
      end
      mfsc_pkg::ST_DIVX: begin
        if (status.div_done) state_nxt = mfsc_pkg::ST_DIVY;
      end
      mfsc_pkg::ST_DIVY: begin
        if (status.div_done) state_nxt = mfsc_pkg::ST_INDEX;
      end
      mfsc_pkg::ST_INDEX: state_nxt = mfsc_pkg::ST_READ;
      mfsc_pkg::ST_READ:  state_nxt = mfsc_pkg::ST_DONE;
      mfsc_pkg::ST_DONE: begin
        if (status.out_free) state_nxt = mfsc_pkg::ST_IDLE;
      end
      default: state_nxt = mfsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      mfsc_pkg::ST_CLEAR: cmd.clr_we = 1'b1;
      mfsc_pkg::ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      mfsc_pkg::ST_DECODE: begin
        cmd.decode          = 1'b1;
        cmd.src_load_direct = render && direct_src;
        cmd.div_start       = render && status.mode == mfsc_pkg::MODE_SCALED;
      end
      mfsc_pkg::ST_DIVX: begin
        cmd.sx_load_div = status.div_done;
        cmd.div_start   = status.div_done;
        cmd.div_sel_y   = 1'b1;
      end
      mfsc_pkg::ST_DIVY:  cmd.sy_load_div = status.div_done;
      mfsc_pkg::ST_INDEX: cmd.idx_load = 1'b1;
      mfsc_pkg::ST_READ:  cmd.mem_rd = 1'b1;
      mfsc_pkg::ST_DONE:  cmd.commit = status.out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/mono_frame_scanout_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// One-bit-per-pixel frame memory for a 400x300 screen (15000 bytes, MSB leftmost) that
// answers bus writes, bus reads, pixel render requests and refresh requests, one request
// at a time, with exactly one result per request. After reset the frame memory is cleared
// by a pass over all 15000 bytes, one byte per cycle, during which in_stall stays high;
// configuration writes are taken throughout. A read or write inside the frame then goes
// through decode, memory read and result; a refresh, a read or write outside the frame,
// a pixel outside the display or a border ring pixel through decode and result; and a
// pixel that maps directly onto the source through decode, index, memory read and
// result. A scaled render request adds two passes through the shared restoring divider,
// one quotient bit per cycle, between decode and index. A result that waits in the
// output register does not stop the next request from being accepted; the block holds it
// back only at its final step. Configuration registers should be written only while the
// block is idle.
module mono_frame_scanout_converter (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mfsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                      cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_cmd,
  input  wire logic [31:0]                      in_address,
  input  wire logic [7:0]                       in_write_data,
  input  wire logic [mfsc_pkg::DIM_W-1:0]       in_pixel_x,
  input  wire logic [mfsc_pkg::DIM_W-1:0]       in_pixel_y,
  input  wire logic [31:0]                      in_now_ms,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [7:0]                       out_read_data,
  output logic      [15:0]                      out_pixel_value,
  output logic                                  out_refresh_done,
  output logic                                  out_dirty_out
);

  // The controller sequences each request; the datapath holds all storage and arithmetic.
  mfsc_pkg::mfsc_cmd_t    cmd;
  mfsc_pkg::mfsc_status_t status;

  mfsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mfsc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_cmd           (in_cmd),
    .in_address       (in_address),
    .in_write_data    (in_write_data),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .in_now_ms        (in_now_ms),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_data    (out_read_data),
    .out_pixel_value  (out_pixel_value),
    .out_refresh_done (out_refresh_done),
    .out_dirty_out    (out_dirty_out)
  );

endmodule
`default_nettype wire
